/* rtl/core/sample_voice_pool_with_stealing_macros.svh */
// Assertion macros for the voice pool; clock aclk, reset aresetn assumed in scope.
`ifndef SAMPLE_VOICE_POOL_WITH_STEALING_MACROS_SVH
`define SAMPLE_VOICE_POOL_WITH_STEALING_MACROS_SVH

// Clocked property, off while reset is held.
`define SVPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Implication checked in the next cycle.
`define SVPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/svps_pkg.sv */
// Shared types, constants and command/status bundles of the voice pool.
package svps_pkg;

    localparam int VOICES      = 32;
    localparam int VIDX_W      = $clog2(VOICES);
    localparam int MAX_SAMPLES = 128;

    localparam int SMP_W  = 7;
    localparam int LEN_W  = 24;
    localparam int STEP_W = 24;
    localparam int POS_W  = 40;
    localparam int FRAC_W = 16;
    localparam int GAIN_W = 16;
    localparam int KIND_W = 2;
    localparam int VOUT_W = 5;
    localparam int QCNT_W = 4;

    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 56;
    localparam int CFG_IDX_W = 2;

    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STEAL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_HIT_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_LENGTH = 2'd1;

    localparam logic [LEN_W-1:0]  HIT_LIMIT_RST   = 24'd14400;
    localparam logic [LEN_W-1:0]  FADE_LENGTH_RST = 24'd2400;
    localparam logic [GAIN_W-1:0] FULL_GAIN       = 16'd32768;

    typedef struct packed {
        logic load_in;
        logic idx_clr;
        logic idx_inc;
        logic best_upd;
        logic sel_free;
        logic sel_oldest;
        logic write_voice;
        logic out_trig;
        logic rd_voice;
        logic clear_active;
        logic eval_latch;
        logic div_step;
        logic res_commit;
        logic out_pend_last;
    } svps_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic reject;
        logic cur_active;
        logic idx_last;
        logic expired;
        logic need_fade;
        logic div_done;
        logic pend_valid;
        logic out_free;
    } svps_stat_t;

endpackage

/* rtl/core/svps_dp.sv */
// Datapath: voice store, steal search, play window, fade divider, output register.
module svps_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  svps_pkg::svps_cmd_t                   cmd,
    output svps_pkg::svps_stat_t                  stat,
    input  logic                                  s_tuser,
    input  logic [svps_pkg::S_DATA_W-1:0]         s_tdata,
    input  logic                                  cfg_valid,
    input  logic [svps_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [svps_pkg::LEN_W-1:0]            cfg_data,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [svps_pkg::M_DATA_W-1:0]         m_tdata,
    output logic [svps_pkg::KIND_W-1:0]           m_tuser,
    output logic                                  m_tlast
);
    import svps_pkg::*;

    logic [LEN_W-1:0] hit_reg, fade_reg;

    logic [SMP_W-1:0]  sidx_reg;
    logic [LEN_W-1:0]  slen_reg;
    logic [STEP_W-1:0] step_reg;

    logic [VOICES-1:0] act_reg;
    logic [SMP_W-1:0]  smp_mem [VOICES];
    logic [LEN_W-1:0]  len_mem [VOICES];
    logic [STEP_W-1:0] stp_mem [VOICES];
    logic [POS_W-1:0]  pos_mem [VOICES];

    logic [VIDX_W-1:0] idx_reg;
    logic [POS_W-1:0]  best_reg;
    logic [VIDX_W-1:0] best_idx_reg;
    logic              have_best_reg;
    logic [VIDX_W-1:0] vsel_reg;
    logic [KIND_W-1:0] kind_reg;

    logic [LEN_W-1:0]  win_reg, len_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [SMP_W-1:0]  smp_reg;
    logic [STEP_W-1:0] stp_reg;
    logic [LEN_W-1:0]  rdi_reg;
    logic [POS_W-1:0]  rem_reg;
    logic [GAIN_W-1:0] q_reg;
    logic [QCNT_W-1:0] dcnt_reg;

    logic              pend_valid_reg;
    logic [VIDX_W-1:0] pend_voice_reg;
    logic [SMP_W-1:0]  pend_smp_reg;
    logic [LEN_W-1:0]  pend_rdi_reg;
    logic [GAIN_W-1:0] pend_gain_reg;

    logic              out_valid_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic [VIDX_W-1:0] out_voice_reg;
    logic [SMP_W-1:0]  out_smp_reg;
    logic [LEN_W-1:0]  out_rdi_reg;
    logic [GAIN_W-1:0] out_gain_reg;
    logic              out_last_reg;

    logic [SMP_W-1:0]  in_sidx;
    logic [LEN_W-1:0]  in_slen;
    logic              in_reject;
    logic [POS_W-1:0]  cur_pos;
    logic              new_best;
    logic [POS_W-1:0]  lim;
    logic [POS_W-1:0]  gap;
    logic [LEN_W-1:0]  pos_int;
    logic [LEN_W-1:0]  rdi_calc;
    logic [POS_W:0]    dv_sh;
    logic              dv_fits;
    logic              out_free;

    assign in_sidx   = s_tdata[SMP_W-1:0];
    assign in_slen   = s_tdata[SMP_W +: LEN_W];
    assign in_reject = (in_slen == '0) ||
                       ({1'b0, in_sidx} >= (SMP_W+1)'(MAX_SAMPLES));

    assign cur_pos  = pos_mem[idx_reg];
    assign new_best = !have_best_reg || (cur_pos > best_reg);

    assign lim      = {win_reg, {FRAC_W{1'b0}}};
    assign gap      = lim - pos_reg;
    assign pos_int  = pos_reg[POS_W-1:FRAC_W];
    assign rdi_calc = (pos_int >= len_reg) ? (len_reg - 1'b1) : pos_int;

    // divisor 2*fade shifted to the current quotient bit
    assign dv_sh   = ({{(POS_W-LEN_W){1'b0}}, fade_reg, 1'b0}) << dcnt_reg;
    assign dv_fits = {1'b0, rem_reg} >= dv_sh;

    assign out_free = !out_valid_reg || m_tready;

    assign stat.is_tick    = s_tuser;
    assign stat.reject     = in_reject;
    assign stat.cur_active = act_reg[idx_reg];
    assign stat.idx_last   = (idx_reg == VIDX_W'(VOICES-1));
    assign stat.expired    = (pos_reg >= lim);
    assign stat.need_fade  = (fade_reg != '0) && (gap < {fade_reg, {FRAC_W{1'b0}}});
    assign stat.div_done   = (dcnt_reg == '0);
    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = out_free;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg  <= HIT_LIMIT_RST;
            fade_reg <= FADE_LENGTH_RST;
        end else if (cfg_valid) begin
            if (cfg_index == REG_HIT_LIMIT) begin
                hit_reg <= cfg_data;
            end else if (cfg_index == REG_FADE_LENGTH) begin
                fade_reg <= cfg_data;
            end
        end
    end

    // active flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= '0;
        end else if (cmd.write_voice) begin
            act_reg[vsel_reg] <= 1'b1;
        end else if (cmd.clear_active) begin
            act_reg[idx_reg] <= 1'b0;
        end
    end

    // voice store
    always_ff @(posedge aclk) begin
        if (cmd.write_voice) begin
            smp_mem[vsel_reg] <= sidx_reg;
            len_mem[vsel_reg] <= slen_reg;
            stp_mem[vsel_reg] <= step_reg;
            pos_mem[vsel_reg] <= '0;
        end else if (cmd.res_commit) begin
            pos_mem[idx_reg] <= pos_reg + {{(POS_W-STEP_W){1'b0}}, stp_reg};
        end
    end

    // request, walk and search registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            sidx_reg <= in_sidx;
            slen_reg <= in_slen;
            step_reg <= s_tdata[SMP_W+LEN_W +: STEP_W];
            kind_reg <= in_reject ? KIND_REJECT : KIND_FREE;
            vsel_reg <= '0;
        end else if (cmd.sel_free) begin
            vsel_reg <= idx_reg;
            kind_reg <= KIND_FREE;
        end else if (cmd.sel_oldest) begin
            vsel_reg <= new_best ? idx_reg : best_idx_reg;
            kind_reg <= KIND_STEAL;
        end
        if (cmd.idx_clr) begin
            idx_reg       <= '0;
            have_best_reg <= 1'b0;
        end else begin
            if (cmd.idx_inc) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.best_upd && new_best) begin
                best_reg      <= cur_pos;
                best_idx_reg  <= idx_reg;
                have_best_reg <= 1'b1;
            end
        end
        if (cmd.rd_voice) begin
            len_reg <= len_mem[idx_reg];
            win_reg <= (len_mem[idx_reg] < hit_reg) ? len_mem[idx_reg] : hit_reg;
            pos_reg <= cur_pos;
            smp_reg <= smp_mem[idx_reg];
            stp_reg <= stp_mem[idx_reg];
        end
        if (cmd.eval_latch) begin
            rdi_reg  <= rdi_calc;
            rem_reg  <= gap;
            dcnt_reg <= QCNT_W'(GAIN_W-1);
            q_reg    <= stat.need_fade ? '0 : FULL_GAIN;
        end else if (cmd.div_step) begin
            if (dv_fits) begin
                rem_reg         <= rem_reg - dv_sh[POS_W-1:0];
                q_reg[dcnt_reg] <= 1'b1;
            end
            dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    // pending read result: held back until the next one shows whether it is last
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.res_commit) begin
            pend_valid_reg <= 1'b1;
        end else if (cmd.out_pend_last) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_commit) begin
            pend_voice_reg <= idx_reg;
            pend_smp_reg   <= smp_reg;
            pend_rdi_reg   <= rdi_reg;
            pend_gain_reg  <= q_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_trig || cmd.out_pend_last ||
                     (cmd.res_commit && pend_valid_reg)) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_trig) begin
            out_kind_reg  <= kind_reg;
            out_voice_reg <= vsel_reg;
            out_smp_reg   <= sidx_reg;
            out_rdi_reg   <= '0;
            out_gain_reg  <= '0;
            out_last_reg  <= 1'b1;
        end else if (cmd.out_pend_last || (cmd.res_commit && pend_valid_reg)) begin
            out_kind_reg  <= KIND_READ;
            out_voice_reg <= pend_voice_reg;
            out_smp_reg   <= pend_smp_reg;
            out_rdi_reg   <= pend_rdi_reg;
            out_gain_reg  <= pend_gain_reg;
            out_last_reg  <= cmd.out_pend_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_DATA_W-VOUT_W-SMP_W-LEN_W-GAIN_W){1'b0}},
                       out_gain_reg, out_rdi_reg, out_smp_reg, VOUT_W'(out_voice_reg)};

endmodule

/* rtl/core/svps_ctrl.sv */
// Controller: sequences trigger search, tick walk and result hand-off.
module svps_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  svps_pkg::svps_stat_t  stat,
    output svps_pkg::svps_cmd_t   cmd
);
    import svps_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCAN  = 4'd1;
    localparam logic [3:0] ST_WRITE = 4'd2;
    localparam logic [3:0] ST_EMIT  = 4'd3;
    localparam logic [3:0] ST_TLOAD = 4'd4;
    localparam logic [3:0] ST_TEVAL = 4'd5;
    localparam logic [3:0] ST_TDIV  = 4'd6;
    localparam logic [3:0] ST_TRES  = 4'd7;
    localparam logic [3:0] ST_TEND  = 4'd8;

    logic [3:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    cmd.idx_clr = 1'b1;
                    if (stat.is_tick) begin
                        state_next = ST_TLOAD;
                    end else if (stat.reject) begin
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (!stat.cur_active) begin
                    cmd.sel_free = 1'b1;
                    state_next   = ST_WRITE;
                end else if (stat.idx_last) begin
                    cmd.sel_oldest = 1'b1;
                    state_next     = ST_WRITE;
                end else begin
                    cmd.best_upd = 1'b1;
                    cmd.idx_inc  = 1'b1;
                end
            end
            ST_WRITE: begin
                if (stat.out_free) begin
                    cmd.write_voice = 1'b1;
                    cmd.out_trig    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.out_trig = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_TLOAD: begin
                if (stat.cur_active) begin
                    cmd.rd_voice = 1'b1;
                    state_next   = ST_TEVAL;
                end else if (stat.idx_last) begin
                    state_next = ST_TEND;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_TEVAL: begin
                if (stat.expired) begin
                    cmd.clear_active = 1'b1;
                    if (stat.idx_last) begin
                        state_next = ST_TEND;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_TLOAD;
                    end
                end else begin
                    cmd.eval_latch = 1'b1;
                    state_next     = stat.need_fade ? ST_TDIV : ST_TRES;
                end
            end
            ST_TDIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    state_next = ST_TRES;
                end
            end
            ST_TRES: begin
                if (!stat.pend_valid || stat.out_free) begin
                    cmd.res_commit = 1'b1;
                    if (stat.idx_last) begin
                        state_next = ST_TEND;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_TLOAD;
                    end
                end
            end
            ST_TEND: begin
                if (!stat.pend_valid) begin
                    state_next = ST_IDLE;
                end else if (stat.out_free) begin
                    cmd.out_pend_last = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/sample_voice_pool_with_stealing.sv */
// Sample voice pool: top level joining controller and datapath.
// Trigger: the scan stops at the first idle voice; with all voices active the oldest is stolen.
// Tick: all 32 voices are walked; idle voices are skipped, expired ones are freed, and each
// other active voice is read, run through the fade divider when in the fade-out, and emitted.
// One request at a time; results leave through a one-deep output register.
// aresetn (synchronous, active low) stops all voices and restores the register defaults.
module sample_voice_pool_with_stealing (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [svps_pkg::S_DATA_W-1:0]         s_tdata,  // sample_index, sample_length, rate_step
    input  logic                                  s_tuser,  // func
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [svps_pkg::M_DATA_W-1:0]         m_tdata,  // voice, sample_index_res, read_index, gain
    output logic [svps_pkg::KIND_W-1:0]           m_tuser,  // kind
    output logic                                  m_tlast,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [svps_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [svps_pkg::LEN_W-1:0]            cfg_data
);
    import svps_pkg::*;
    `include "sample_voice_pool_with_stealing_macros.svh"

    svps_cmd_t  cmd;
    svps_stat_t stat;

    assign cfg_ready = 1'b1;

    svps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    svps_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    `SVPS_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready, "request overlap")
    `SVPS_ASSERT(a_trig_last, (m_tvalid && (m_tuser != KIND_READ)) |-> m_tlast, "trigger not last")
    `SVPS_ASSERT(a_gain_range, m_tvalid |-> (m_tdata[51:36] <= FULL_GAIN), "gain above full")
    `SVPS_ASSERT(a_trig_zero, (m_tvalid && (m_tuser != KIND_READ)) |-> (m_tdata[51:12] == '0), "trigger data")

endmodule

/* sim/sample_voice_pool_with_stealing_test.sv */
// Self-checking regression bench for the sample voice pool with voice stealing.
`timescale 1ns / 100ps

module sample_voice_pool_with_stealing_test;
    import svps_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [VOUT_W-1:0] voice;
        logic [SMP_W-1:0]  smp;
        logic [LEN_W-1:0]  frame;
        logic [GAIN_W-1:0] gain;
        logic              last;
    } voice_result_t;

    // Tracks the voice pool state and the results that accepted requests should produce.
    class voice_schedule;
        bit [LEN_W-1:0]  hit_limit;
        bit [LEN_W-1:0]  fade_length;
        bit              active [VOICES];
        bit [SMP_W-1:0]  smp [VOICES];
        bit [LEN_W-1:0]  len [VOICES];
        bit [STEP_W-1:0] step [VOICES];
        bit [POS_W-1:0]  pos [VOICES];
        voice_result_t   pending[$];
        int errors, n_free, n_steal, n_reject, n_read;

        function new();
            hit_limit = HIT_LIMIT_RST;
            fade_length = FADE_LENGTH_RST;
            foreach (active[i]) begin
                active[i] = 0; smp[i] = 0; len[i] = 0; step[i] = 0; pos[i] = 0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
            if (idx == REG_HIT_LIMIT) hit_limit = val;
            else if (idx == REG_FADE_LENGTH) fade_length = val;
        endfunction

        function void note_request(bit is_tick, bit [SMP_W-1:0] sidx, bit [LEN_W-1:0] slen,
                                   bit [STEP_W-1:0] srate);
            voice_result_t r;
            int v, oldest, n;
            bit [POS_W-1:0] best;
            bit [LEN_W-1:0] win, frame;
            longint unsigned lim, d;
            r = '0;
            if (!is_tick) begin
                r.smp = sidx;
                r.last = 1;
                if (slen == 0) begin
                    r.kind = KIND_REJECT;
                    n_reject++;
                end else begin
                    v = -1; oldest = 0; best = '0;
                    for (int i = 0; i < VOICES; i++) begin
                        if (!active[i]) begin
                            v = i;
                            break;
                        end
                        if (i == 0 || pos[i] > best) begin
                            best = pos[i];
                            oldest = i;
                        end
                    end
                    r.kind = (v < 0) ? KIND_STEAL : KIND_FREE;
                    if (v < 0) begin
                        v = oldest;
                        n_steal++;
                    end else n_free++;
                    active[v] = 1; smp[v] = sidx; len[v] = slen; step[v] = srate; pos[v] = 0;
                    r.voice = VOUT_W'(v);
                end
                pending.insert(pending.size(), r);
                return;
            end
            n = 0;
            for (int i = 0; i < VOICES; i++) begin
                if (!active[i]) continue;
                win = (len[i] < hit_limit) ? len[i] : hit_limit;
                lim = longint'(win) << 16;
                if (pos[i] >= lim) begin
                    active[i] = 0;
                    continue;
                end
                frame = LEN_W'(pos[i] >> 16);
                if (frame >= len[i]) frame = len[i] - 1'b1;
                d = lim - pos[i];
                r.kind = KIND_READ;
                r.voice = VOUT_W'(i);
                r.smp = smp[i];
                r.frame = frame;
                r.last = 0;
                if (fade_length != 0 && d < (longint'(fade_length) << 16))
                    r.gain = GAIN_W'(d / (longint'(fade_length) * 2));
                else
                    r.gain = FULL_GAIN;
                pending.insert(pending.size(), r);
                n++;
                n_read++;
                pos[i] = pos[i] + step[i];
            end
            if (n > 0) pending[pending.size() - 1].last = 1;
        endfunction

        function void check_result(voice_result_t got);
            voice_result_t exp_r;
            if (pending.size() == 0) begin
                $display("%0t: result with nothing expected: %p", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.kind !== exp_r.kind)
                $display("%0t: kind exp %0d got %0d", $time, exp_r.kind, got.kind);
            if (got.voice !== exp_r.voice)
                $display("%0t: voice exp %0d got %0d", $time, exp_r.voice, got.voice);
            if (got.smp !== exp_r.smp)
                $display("%0t: sample exp %0d got %0d", $time, exp_r.smp, got.smp);
            if (got.frame !== exp_r.frame)
                $display("%0t: read index exp %0d got %0d", $time, exp_r.frame, got.frame);
            if (got.gain !== exp_r.gain)
                $display("%0t: gain exp %0d got %0d", $time, exp_r.gain, got.gain);
            if (got.last !== exp_r.last)
                $display("%0t: last exp %0d got %0d", $time, exp_r.last, got.last);
            if (got !== exp_r) errors++;
        endfunction
    endclass

    logic                aclk, aresetn;
    logic                s_tvalid, s_tready, s_tuser;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid, m_tready, m_tlast;
    logic [M_DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]   m_tuser;
    logic                cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEN_W-1:0]    cfg_data;

    voice_schedule sched = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int n_requests = 0;

    sample_voice_pool_with_stealing dut (.*);

    always begin
        aclk = 1'b1; #10;
        aclk = 1'b0; #10;
    end

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sched.check_result({m_tuser, m_tdata[4:0], m_tdata[11:5], m_tdata[35:12],
                                m_tdata[51:36], m_tlast});
    end

    task automatic send_request(bit is_tick, bit [SMP_W-1:0] sidx, bit [LEN_W-1:0] slen,
                                bit [STEP_W-1:0] srate);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser = is_tick;
        s_tdata = {1'b0, srate, slen, sidx};
        do @(posedge aclk); while (!s_tready);
        sched.note_request(is_tick, sidx, slen, srate);
        n_requests++;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (sched.pending.size() == 0);
        // a tick may still be walking voices that produce no result
        repeat (800) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        sched.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_request(bit force_trigger);
        bit [LEN_W-1:0] slen;
        bit [STEP_W-1:0] srate;
        int pick;
        pick = $urandom_range(99);
        slen = (pick < 70) ? LEN_W'($urandom_range(24, 1)) :
               (pick < 90) ? LEN_W'($urandom) : (pick < 95) ? '0 : '1;
        pick = $urandom_range(99);
        srate = (pick < 70) ? STEP_W'($urandom_range(32'h30000)) :
                (pick < 90) ? STEP_W'($urandom) : '0;
        send_request(!force_trigger && $urandom_range(99) < 45, SMP_W'($urandom), slen, srate);
    endtask

    task automatic run_phase(logic [LEN_W-1:0] hit, logic [LEN_W-1:0] fade,
                             int idle, int stall, int burst, int count);
        wait_idle();
        write_reg(REG_HIT_LIMIT, hit);
        write_reg(REG_FADE_LENGTH, fade);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        // a run of triggers fills the pool so later ones must steal
        repeat (burst) random_request(1'b1);
        repeat (count) random_request(1'b0);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_HIT_LIMIT;
        cfg_data = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty tick, reject, extreme fields, one-frame sample, stalled voice
        send_request(1'b1, 7'd0, 24'd0, 24'd0);
        send_request(1'b0, 7'd127, 24'd0, 24'hFFFFFF);
        send_request(1'b0, 7'd0, 24'd1, 24'd0);
        send_request(1'b0, 7'd127, 24'hFFFFFF, 24'hFFFFFF);
        send_request(1'b0, 7'd42, 24'd3, 24'h010000);
        repeat (5) send_request(1'b1, 7'd0, 24'd0, 24'd0);
        wait_idle();
        write_reg(REG_HIT_LIMIT, 24'd2);
        write_reg(REG_FADE_LENGTH, 24'd1);
        send_request(1'b0, 7'd5, 24'd10, 24'h008000);
        repeat (6) send_request(1'b1, 7'd0, 24'd0, 24'd0);

        run_phase(24'd8, 24'd4, 0, 0, 0, 40);
        run_phase(24'd1, 24'd1, 71, 0, 0, 35);
        run_phase(24'hFFFFFF, 24'hFFFFFF, 0, 71, 36, 20);
        run_phase(24'd12, 24'd6, 32, 32, 34, 20);
        run_phase(24'd16, 24'hFFFFFF, 0, 0, 0, 30);

        wait_idle();
        $display("covered %0d requests: %0d free starts, %0d steals, %0d rejects, %0d reads",
                 n_requests, sched.n_free, sched.n_steal, sched.n_reject, sched.n_read);
        if (sched.errors == 0)
            $display("sample_voice_pool_with_stealing regression: pass");
        else
            $display("sample_voice_pool_with_stealing regression: fail");
        $finish;
    end

    initial begin
        #50ms;
        $display("timeout with %0d results outstanding", sched.pending.size());
        $display("sample_voice_pool_with_stealing regression: fail");
        $finish;
    end

endmodule
